[rtl/stq_pkg.sv]
`timescale 1ns / 1ps
// Package for the sorted timer queue: sizes, codes, payload and control types.
// Used by every module of the block; depends on nothing.
package stq_pkg;

   localparam int NUM_TIMERS = 16;
   localparam int TID_W      = 4;
   localparam int IDX_W      = $clog2(NUM_TIMERS);
   localparam int CNT_W      = $clog2(NUM_TIMERS + 1);
   localparam int VAL_W      = 32;
   localparam logic [VAL_W-1:0] HALF_RANGE = 32'h7FFF_FFFF;

   typedef enum logic [2:0] {
      ACT_TICK     = 3'd0,
      ACT_START    = 3'd1,
      ACT_STOP     = 3'd2,
      ACT_SET_PER  = 3'd3,
      ACT_GET_PER  = 3'd4,
      ACT_ONESHOT  = 3'd5,
      ACT_PERIODIC = 3'd6,
      ACT_INIT     = 3'd7
   } action_type;

   typedef enum logic [1:0] {
      KIND_DONE    = 2'd0,
      KIND_EXPIRED = 2'd1,
      KIND_PERIOD  = 2'd2,
      KIND_ERROR   = 2'd3
   } kind_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_EXEC,
      ST_ARM,
      ST_INS,
      ST_TCHK,
      ST_TPOST,
      ST_EMIT
   } state_type;

   typedef struct packed {
      action_type        action;
      logic [TID_W-1:0]  timer_id;
      logic [VAL_W-1:0]  value;
      logic              periodic_mode;
   } req_type;

   typedef struct packed {
      kind_type          event_kind;
      logic [TID_W-1:0]  event_timer;
      logic [VAL_W-1:0]  read_value;
      logic              last;
   } rsp_type;

   // Command from the sequencer to the queue order store.
   typedef struct packed {
      logic              rm_en;
      logic [TID_W-1:0]  rm_id;
      logic              ins_en;
      logic [IDX_W-1:0]  ins_pos;
      logic [TID_W-1:0]  ins_id;
      logic [IDX_W-1:0]  rd_idx;
   } ord_op_type;

endpackage

[rtl/stq_alu.sv]
`timescale 1ns / 1ps
// Shared 32-bit add/subtract unit of the sorted timer queue.
// Depends on stq_pkg.
module stq_alu import stq_pkg::*; (
   input  logic [VAL_W-1:0] a,
   input  logic [VAL_W-1:0] b,
   input  logic             sub,
   output logic [VAL_W-1:0] sum
);

   // Add, or subtract through inverted operand and carry in
   assign sum = a + (b ^ {VAL_W{sub}}) + {{(VAL_W-1){1'b0}}, sub};

endmodule

[rtl/stq_order.sv]
`timescale 1ns / 1ps
// Queue order store: timer ids sorted by deadline, with removal and insertion by shift.
// Depends on stq_pkg.
module stq_order import stq_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  ord_op_type       op,
   output logic [TID_W-1:0] rd_id,
   output logic [CNT_W-1:0] count
);

   logic [TID_W-1:0] order_ff [NUM_TIMERS];
   logic [TID_W-1:0] order_in [NUM_TIMERS];
   logic [CNT_W-1:0] count_ff, count_in;
   logic             found;
   logic [IDX_W-1:0] found_idx;

   assign rd_id = order_ff[op.rd_idx];
   assign count = count_ff;

   // Locate the first queued entry holding the id to remove
   always_comb begin
      found     = 1'b0;
      found_idx = '0;
      for (int i = 0; i < NUM_TIMERS; i++) begin
         if (!found && (CNT_W'(i) < count_ff) && (order_ff[i] == op.rm_id)) begin
            found     = 1'b1;
            found_idx = IDX_W'(i);
         end
      end
   end

   // Shift entries down on removal, up on insertion
   always_comb begin
      order_in = order_ff;
      count_in = count_ff;
      if (op.rm_en && found) begin
         for (int i = 0; i < NUM_TIMERS - 1; i++) begin
            if (IDX_W'(i) >= found_idx) order_in[i] = order_ff[i+1];
         end
         count_in = count_ff - CNT_W'(1);
      end else if (op.ins_en) begin
         for (int i = 1; i < NUM_TIMERS; i++) begin
            if (IDX_W'(i) > op.ins_pos) order_in[i] = order_ff[i-1];
         end
         order_in[op.ins_pos] = op.ins_id;
         count_in = count_ff + CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      order_ff <= order_in;
      if (reset) count_ff <= '0;
      else       count_ff <= count_in;
   end

endmodule

[rtl/sorted_timer_queue_unit.sv]
`timescale 1ns / 1ps
// Sorted timer queue top level: command sequencer, timer stores, output register.
// Depends on stq_pkg, stq_alu and stq_order.
//
// Usage: commands enter on req_valid/req_data and are taken when req_stall is
// low; req_stall is high while a command is being worked on. Results leave on
// rsp_valid/rsp_data through an output register, with last set on the final
// result of a command. A tick gives one expired result per popped timer and a
// closing done result; every other command gives one result.
// Timing: a simple command passes through execute and emit before its result is
// registered. A start walks the sorted queue through the shared adder, one entry
// a cycle. A tick checks the head timer and, for each popped timer, emits an
// expired result and, when it re-arms, computes the new deadline through the
// shared add/subtract unit and walks the queue, one entry a cycle. The next
// command is taken in the cycle after the last result is loaded.
// Reset clears the tick count, all periods, deadlines, flags and the queue.
// When the receiver holds rsp_stall, the result holds and the sequencer waits
// before loading the next one.
module sorted_timer_queue_unit import stq_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_data
);

   state_type        state_ff, state_in;
   logic [VAL_W-1:0] now_ff, now_in;
   logic [VAL_W-1:0] period_ff [NUM_TIMERS];
   logic [VAL_W-1:0] period_in [NUM_TIMERS];
   logic [VAL_W-1:0] deadline_ff [NUM_TIMERS];
   logic [VAL_W-1:0] deadline_in [NUM_TIMERS];
   logic [NUM_TIMERS-1:0] active_ff, active_in, periodic_ff, periodic_in;
   req_type          cmd_ff, cmd_in;
   logic [TID_W-1:0] cur_ff, cur_in;
   logic [CNT_W-1:0] pos_ff, pos_in, pops_ff, pops_in;
   logic [VAL_W-1:0] arm_p_ff, arm_p_in, ins_dl_ff, ins_dl_in;
   logic             ins_tick_ff, ins_tick_in, ret_tpost_ff, ret_tpost_in;
   rsp_type          pend_ff, pend_in, rsp_data_ff, rsp_data_in;
   logic             rsp_valid_ff, rsp_valid_in;

   logic [VAL_W-1:0] alu_a, alu_b, alu_sum;
   logic             alu_sub;
   ord_op_type       ord_op;
   logic [TID_W-1:0] ord_rd_id;
   logic [CNT_W-1:0] ord_count;
   logic             can_emit, id_bad;
   logic [VAL_W-1:0] entry_dl, cur_period;

   stq_alu u_alu (.a(alu_a), .b(alu_b), .sub(alu_sub), .sum(alu_sum));

   stq_order u_order (
      .clock(clock), .reset(reset), .op(ord_op), .rd_id(ord_rd_id), .count(ord_count)
   );

   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;
   assign can_emit  = !rsp_valid_ff || !rsp_stall;
   assign id_bad    = ({1'b0, cmd_ff.timer_id} >= (TID_W+1)'(NUM_TIMERS));
   assign entry_dl  = deadline_ff[ord_rd_id];
   assign cur_period = period_ff[cur_ff];

   // Sequencer: next state, store updates and shared unit operands
   always_comb begin
      state_in     = state_ff;
      now_in       = now_ff;
      period_in    = period_ff;
      deadline_in  = deadline_ff;
      active_in    = active_ff;
      periodic_in  = periodic_ff;
      cmd_in       = cmd_ff;
      cur_in       = cur_ff;
      pos_in       = pos_ff;
      pops_in      = pops_ff;
      arm_p_in     = arm_p_ff;
      ins_dl_in    = ins_dl_ff;
      ins_tick_in  = ins_tick_ff;
      ret_tpost_in = ret_tpost_ff;
      pend_in      = pend_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      alu_a        = now_ff;
      alu_b        = {{(VAL_W-1){1'b0}}, 1'b1};
      alu_sub      = 1'b0;
      ord_op       = '0;
      ord_op.rd_idx = '0;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd_in   = req_data;
               cur_in   = req_data.timer_id;
               state_in = ST_EXEC;
            end
         end

         ST_EXEC: begin
            pend_in      = '{KIND_DONE, cur_ff, '0, 1'b1};
            ret_tpost_in = 1'b0;
            state_in     = ST_EMIT;
            if (cmd_ff.action == ACT_TICK) begin
               now_in   = alu_sum;
               pops_in  = '0;
               state_in = ST_TCHK;
            end else if (!id_bad) begin
               unique case (cmd_ff.action)
                  ACT_START: begin
                     ord_op.rm_en = 1'b1;
                     ord_op.rm_id = cur_ff;
                     arm_p_in     = cur_period;
                     ins_tick_in  = 1'b0;
                     state_in     = ST_ARM;
                  end
                  ACT_STOP: begin
                     if (!active_ff[cur_ff]) begin
                        pend_in.event_kind = KIND_ERROR;
                     end else begin
                        ord_op.rm_en      = 1'b1;
                        ord_op.rm_id      = cur_ff;
                        active_in[cur_ff] = 1'b0;
                     end
                  end
                  ACT_SET_PER:  period_in[cur_ff] = cmd_ff.value;
                  ACT_GET_PER: begin
                     pend_in.event_kind = KIND_PERIOD;
                     pend_in.read_value = cur_period;
                  end
                  ACT_ONESHOT:  periodic_in[cur_ff] = 1'b0;
                  ACT_PERIODIC: periodic_in[cur_ff] = 1'b1;
                  ACT_INIT: begin
                     ord_op.rm_en        = 1'b1;
                     ord_op.rm_id        = cur_ff;
                     periodic_in[cur_ff] = cmd_ff.periodic_mode;
                     active_in[cur_ff]   = 1'b0;
                     deadline_in[cur_ff] = '0;
                     period_in[cur_ff]   = cmd_ff.value;
                  end
                  default: ;
               endcase
            end
         end

         // Compute the new deadline and open the insertion walk
         ST_ARM: begin
            alu_b               = arm_p_ff;
            deadline_in[cur_ff] = alu_sum;
            ins_dl_in           = alu_sum;
            active_in[cur_ff]   = 1'b1;
            pos_in              = '0;
            state_in            = ST_INS;
         end

         // Walk the queue: insert before the first strictly later deadline
         ST_INS: begin
            ord_op.rd_idx = pos_ff[IDX_W-1:0];
            alu_a         = entry_dl;
            alu_b         = ins_dl_ff;
            alu_sub       = 1'b1;
            if (ord_count >= CNT_W'(NUM_TIMERS) || pos_ff >= ord_count ||
                (alu_sum != '0 && alu_sum < HALF_RANGE)) begin
               if (ord_count < CNT_W'(NUM_TIMERS)) begin
                  ord_op.ins_en  = 1'b1;
                  ord_op.ins_pos = pos_ff[IDX_W-1:0];
                  ord_op.ins_id  = cur_ff;
               end
               if (ins_tick_ff) begin
                  state_in = ST_TCHK;
               end else begin
                  pend_in      = '{KIND_DONE, cur_ff, '0, 1'b1};
                  ret_tpost_in = 1'b0;
                  state_in     = ST_EMIT;
               end
            end else begin
               pos_in = pos_ff + CNT_W'(1);
            end
         end

         // Check the head timer for expiry
         ST_TCHK: begin
            ord_op.rd_idx = '0;
            alu_b         = entry_dl;
            alu_sub       = 1'b1;
            ret_tpost_in  = 1'b0;
            pend_in       = '{KIND_DONE, '0, '0, 1'b1};
            state_in      = ST_EMIT;
            if (ord_count != '0 && pops_ff != CNT_W'(NUM_TIMERS) && alu_sum < HALF_RANGE) begin
               ord_op.rm_en = 1'b1;
               ord_op.rm_id = ord_rd_id;
               cur_in       = ord_rd_id;
               pops_in      = pops_ff + CNT_W'(1);
               pend_in      = '{KIND_EXPIRED, ord_rd_id, '0, 1'b0};
               ret_tpost_in = 1'b1;
            end
         end

         // Re-arm a periodic timer or retire a one-shot one
         ST_TPOST: begin
            if (periodic_ff[cur_ff] && active_ff[cur_ff]) begin
               arm_p_in    = (cur_period == '0) ? {{(VAL_W-1){1'b0}}, 1'b1} : cur_period;
               ins_tick_in = 1'b1;
               state_in    = ST_ARM;
            end else begin
               active_in[cur_ff] = 1'b0;
               state_in          = ST_TCHK;
            end
         end

         // Load the pending result once the output register is free
         ST_EMIT: begin
            if (can_emit) begin
               rsp_data_in  = pend_ff;
               rsp_valid_in = 1'b1;
               state_in     = ret_tpost_ff ? ST_TPOST : ST_IDLE;
            end
         end

         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         now_ff       <= '0;
         active_ff    <= '0;
         periodic_ff  <= '0;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < NUM_TIMERS; i++) begin
            period_ff[i]   <= '0;
            deadline_ff[i] <= '0;
         end
      end else begin
         state_ff     <= state_in;
         now_ff       <= now_in;
         active_ff    <= active_in;
         periodic_ff  <= periodic_in;
         rsp_valid_ff <= rsp_valid_in;
         period_ff    <= period_in;
         deadline_ff  <= deadline_in;
      end
      cmd_ff       <= cmd_in;
      cur_ff       <= cur_in;
      pos_ff       <= pos_in;
      pops_ff      <= pops_in;
      arm_p_ff     <= arm_p_in;
      ins_dl_ff    <= ins_dl_in;
      ins_tick_ff  <= ins_tick_in;
      ret_tpost_ff <= ret_tpost_in;
      pend_ff      <= pend_in;
      rsp_data_ff  <= rsp_data_in;
   end

   // A stalled result holds its value
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("stalled result changed");

   // The queue never holds more than the timer count
   a_count_max: assert property (@(posedge clock) disable iff (reset)
      ord_count <= CNT_W'(NUM_TIMERS))
      else $error("queue count overflow");

   // Removal and insertion never share a cycle
   a_ord_excl: assert property (@(posedge clock) disable iff (reset)
      !(ord_op.rm_en && ord_op.ins_en))
      else $error("queue remove and insert together");

   // An accepted command makes the block busy in the next cycle
   a_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("command accepted while not going busy");

endmodule

[bench/sorted_timer_queue_unit_tb.sv]
`timescale 1ns / 1ps
// Testbench for sorted_timer_queue_unit: directed and random timer commands with a
// behavioral predictor and a result checker. Depends on stq_pkg and the RTL.
module sorted_timer_queue_unit_tb;
   import stq_pkg::*;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_stall;
   req_type req_data = '0;
   logic    rsp_valid;
   logic    rsp_stall = 1'b0;
   rsp_type rsp_data;

   sorted_timer_queue_unit dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data)
   );

   // Timer state mirror
   logic [31:0]      tick_count;
   logic [31:0]      period_mem [NUM_TIMERS];
   logic [31:0]      deadline_mem [NUM_TIMERS];
   bit               armed [NUM_TIMERS];
   bit               repeating [NUM_TIMERS];
   logic [TID_W-1:0] sorted_ids [NUM_TIMERS];
   int               sorted_len;

   rsp_type pending_events[$];
   int      errors = 0;
   int      hold_left = 0;
   bit      calm = 1'b0;

   initial begin
      forever #4 clock = ~clock;
   end

   initial begin
      #20ms;
      $display("TB_ERROR");
      $finish;
   end

   function automatic void push_event(kind_type k, logic [TID_W-1:0] t, logic [31:0] v, bit l);
      rsp_type r;
      r.event_kind = k;
      r.event_timer = t;
      r.read_value = v;
      r.last = l;
      pending_events.push_back(r);
   endfunction

   function automatic void unlink_timer(int id);
      for (int i = 0; i < sorted_len; i++) begin
         if (sorted_ids[i] == id) begin
            for (int j = i; j < sorted_len - 1; j++) sorted_ids[j] = sorted_ids[j+1];
            sorted_len--;
            return;
         end
      end
   endfunction

   // Insert after every queued timer with an equal or earlier deadline
   function automatic void link_timer(int id);
      int          pos;
      logic [31:0] d;
      for (pos = 0; pos < sorted_len; pos++) begin
         d = deadline_mem[sorted_ids[pos]] - deadline_mem[id];
         if (d != 0 && d < HALF_RANGE) break;
      end
      for (int j = sorted_len; j > pos; j--) sorted_ids[j] = sorted_ids[j-1];
      sorted_ids[pos] = TID_W'(id);
      sorted_len++;
   endfunction

   function automatic void arm_timer(int id, logic [31:0] p);
      unlink_timer(id);
      deadline_mem[id] = tick_count + p;
      link_timer(id);
      armed[id] = 1'b1;
   endfunction

   // Compute the events that one accepted command produces
   function automatic void predict_events(req_type r);
      int          pops;
      int          t;
      logic [31:0] p;
      int          id;
      id = int'(r.timer_id);
      case (r.action)
         ACT_TICK: begin
            tick_count++;
            pops = 0;
            while (sorted_len > 0 && pops < NUM_TIMERS) begin
               t = int'(sorted_ids[0]);
               if (tick_count - deadline_mem[t] >= HALF_RANGE) break;
               unlink_timer(t);
               pops++;
               push_event(KIND_EXPIRED, TID_W'(t), '0, 1'b0);
               if (repeating[t] && armed[t]) begin
                  p = (period_mem[t] == 0) ? 32'd1 : period_mem[t];
                  arm_timer(t, p);
               end else begin
                  armed[t] = 1'b0;
               end
            end
            push_event(KIND_DONE, '0, '0, 1'b1);
            return;
         end
         ACT_START:    arm_timer(id, period_mem[id]);
         ACT_STOP: begin
            if (!armed[id]) begin
               push_event(KIND_ERROR, TID_W'(id), '0, 1'b1);
               return;
            end
            unlink_timer(id);
            armed[id] = 1'b0;
         end
         ACT_SET_PER:  period_mem[id] = r.value;
         ACT_GET_PER: begin
            push_event(KIND_PERIOD, TID_W'(id), period_mem[id], 1'b1);
            return;
         end
         ACT_ONESHOT:  repeating[id] = 1'b0;
         ACT_PERIODIC: repeating[id] = 1'b1;
         default: begin
            unlink_timer(id);
            repeating[id] = r.periodic_mode;
            armed[id] = 1'b0;
            deadline_mem[id] = '0;
            period_mem[id] = r.value;
         end
      endcase
      push_event(KIND_DONE, TID_W'(id), '0, 1'b1);
   endfunction

   // Check each accepted result
   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_events.size() == 0) begin
            $display("%0t: unexpected result, expected none, actual %p", $time, rsp_data);
            errors++;
         end else begin
            want = pending_events.pop_front();
            if (rsp_data.event_kind !== want.event_kind) begin
               $display("%0t: event_kind expected %0d actual %0d", $time,
                        want.event_kind, rsp_data.event_kind);
               errors++;
            end
            if (rsp_data.event_timer !== want.event_timer) begin
               $display("%0t: event_timer expected %0d actual %0d", $time,
                        want.event_timer, rsp_data.event_timer);
               errors++;
            end
            if (rsp_data.read_value !== want.read_value) begin
               $display("%0t: read_value expected %h actual %h", $time,
                        want.read_value, rsp_data.read_value);
               errors++;
            end
            if (rsp_data.last !== want.last) begin
               $display("%0t: last expected %0d actual %0d", $time, want.last, rsp_data.last);
               errors++;
            end
         end
      end
   end

   // Drive the receiver stall: long hold, calm stretch or random idling
   always @(posedge clock) begin
      if (hold_left > 0) begin
         rsp_stall <= 1'b1;
         hold_left--;
      end else if (calm) begin
         rsp_stall <= 1'b0;
      end else begin
         rsp_stall <= ($urandom_range(99) < 27);
      end
   end

   // Offer one transaction, hold it until taken, then maybe idle
   task automatic issue(action_type a, logic [TID_W-1:0] id, logic [31:0] v, bit pm);
      req_type r;
      r.action = a;
      r.timer_id = id;
      r.value = v;
      r.periodic_mode = pm;
      req_valid <= 1'b1;
      req_data <= r;
      do @(posedge clock); while (!(req_valid && !req_stall));
      predict_events(r);
      if (!calm && $urandom_range(99) < 27) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 6)) @(posedge clock);
      end
   endtask

   task automatic drain_events();
      req_valid <= 1'b0;
      while (pending_events.size() != 0) @(posedge clock);
   endtask

   // Every action, equal deadlines, zero period, stop of an idle timer
   task automatic test_directed();
      issue(ACT_STOP, 4'd3, $urandom, 1'b0);
      issue(ACT_GET_PER, 4'd15, $urandom, 1'b1);
      issue(ACT_INIT, 4'd0, 32'd2, 1'b0);
      issue(ACT_INIT, 4'd1, 32'd2, 1'b1);
      issue(ACT_INIT, 4'd2, 32'd0, 1'b1);
      issue(ACT_SET_PER, 4'd15, 32'hFFFF_FFFF, 1'b0);
      issue(ACT_GET_PER, 4'd15, 32'h0, 1'b0);
      issue(ACT_START, 4'd1, 32'hFFFF_FFFF, 1'b1);
      issue(ACT_START, 4'd0, 32'h0, 1'b0);
      issue(ACT_START, 4'd2, 32'h0, 1'b0);
      issue(ACT_TICK, 4'd9, 32'hFFFF_FFFF, 1'b1);
      issue(ACT_TICK, 4'd0, 32'h0, 1'b0);
      issue(ACT_TICK, 4'd0, 32'h0, 1'b0);
      issue(ACT_ONESHOT, 4'd1, 32'h0, 1'b0);
      issue(ACT_PERIODIC, 4'd0, 32'h0, 1'b0);
      issue(ACT_STOP, 4'd2, 32'h0, 1'b0);
      issue(ACT_TICK, 4'd0, 32'h0, 1'b0);
      issue(ACT_TICK, 4'd0, 32'h0, 1'b0);
      issue(ACT_INIT, 4'd0, 32'h8000_0000, 1'b1);
      issue(ACT_INIT, 4'd1, 32'h0, 1'b0);
      drain_events();
   endtask

   // Periodic timers whose re-armed deadline has already passed hit the pop bound
   task automatic test_pop_bound();
      for (int i = 0; i < NUM_TIMERS; i++) issue(ACT_INIT, TID_W'(i), 32'hFFFF_FFFF, 1'b1);
      for (int i = 0; i < NUM_TIMERS; i++) issue(ACT_START, TID_W'(i), 32'h0, 1'b0);
      repeat (3) issue(ACT_TICK, 4'd0, 32'h0, 1'b0);
      for (int i = 0; i < NUM_TIMERS; i++) issue(ACT_STOP, TID_W'(i), 32'h0, 1'b0);
      drain_events();
   endtask

   // Hold the receiver off while the sender keeps offering transactions
   task automatic test_backpressure();
      @(negedge clock);
      hold_left = 300;
      calm = 1'b1;
      @(posedge clock);
      for (int i = 0; i < 24; i++) begin
         if (i % 3 == 0) issue(ACT_TICK, TID_W'($urandom_range(15)), $urandom, 1'b0);
         else            issue(ACT_GET_PER, TID_W'($urandom_range(15)), $urandom, 1'b0);
      end
      @(negedge clock);
      calm = 1'b0;
      @(posedge clock);
      drain_events();
   endtask

   task automatic test_random();
      int          sel;
      logic [31:0] v;
      for (int n = 0; n < 340; n++) begin
         if (n == 150 || n == 200) begin
            @(negedge clock);
            calm = (n == 150);
            @(posedge clock);
         end
         sel = $urandom_range(99);
         case ($urandom_range(9))
            0, 1, 2, 3, 4, 5: v = $urandom_range(0, 12);
            6, 7: v = $urandom_range(0, 2);
            default: v = $urandom;
         endcase
         if (sel < 38)      issue(ACT_TICK, TID_W'($urandom), $urandom, 1'($urandom));
         else if (sel < 58) issue(ACT_START, TID_W'($urandom), $urandom, 1'($urandom));
         else if (sel < 66) issue(ACT_STOP, TID_W'($urandom), $urandom, 1'($urandom));
         else if (sel < 74) issue(ACT_SET_PER, TID_W'($urandom), v, 1'($urandom));
         else if (sel < 80) issue(ACT_GET_PER, TID_W'($urandom), $urandom, 1'($urandom));
         else if (sel < 85) issue(ACT_ONESHOT, TID_W'($urandom), $urandom, 1'($urandom));
         else if (sel < 90) issue(ACT_PERIODIC, TID_W'($urandom), $urandom, 1'($urandom));
         else               issue(ACT_INIT, TID_W'($urandom), v, 1'($urandom));
      end
      drain_events();
   endtask

   initial begin
      tick_count = '0;
      sorted_len = 0;
      for (int i = 0; i < NUM_TIMERS; i++) begin
         period_mem[i] = '0;
         deadline_mem[i] = '0;
         armed[i] = 1'b0;
         repeating[i] = 1'b0;
         sorted_ids[i] = '0;
      end
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_pop_bound();
      test_backpressure();
      test_random();
      repeat (60) @(posedge clock);
      if (errors == 0 && pending_events.size() == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule
